// ===== src/spd_pkg.sv =====
// Shared types and constants for the sphere pair distance core.
// Used by the axis lane, the square-root cell, the output skid and the top level.
// No dependencies.
package spd_pkg;

   // coordinate, box and radius width (unsigned fixed point)
   localparam int COORD_BITS = 32;
   localparam int TAG_BITS   = 32;
   // squared length and square-root widths
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int ROOT_BITS  = COORD_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;

   // stream widths
   localparam int REQ_FIELDS = 8;
   localparam int REQ_W      = REQ_FIELDS * COORD_BITS;
   localparam int RSP_W      = COORD_BITS + TAG_BITS;

   // configuration register indexes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIODIC_MODE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOX_SIZE_X    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOX_SIZE_Y    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOX_SIZE_Z    = 2'd3;

   // side-band travelling with each pair down the pipe
   typedef struct packed {
      logic                  valid;
      logic                  sep;
      logic [COORD_BITS-1:0] rsum;
      logic [TAG_BITS-1:0]   tag;
   } side_type;

   // working set of one square-root cell
   typedef struct packed {
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
      logic [SQ_BITS-1:0]   rad;
   } root_type;

   // one result beat
   typedef struct packed {
      logic                  sep;
      logic [TAG_BITS-1:0]   tag;
      logic [COORD_BITS-1:0] centre;
   } out_type;

endpackage

// ===== src/spd_axis_cell.sv =====
// One axis lane: absolute difference, minimum-image wrap and square.
// Three register stages, advanced together by the shared enable.
// Depends on spd_pkg.
module spd_axis_cell (
   input  logic                           clock,
   input  logic                           en,
   input  logic                           periodic,
   input  logic [spd_pkg::COORD_BITS-1:0] box,
   input  logic [spd_pkg::COORD_BITS-1:0] coord_a,
   input  logic [spd_pkg::COORD_BITS-1:0] coord_b,
   output logic [spd_pkg::SQ_BITS-1:0]    sq
);

   localparam int CW = spd_pkg::COORD_BITS;

   logic [CW-1:0]               d_ff, d_in;
   logic [CW-1:0]               w_ff, w_in;
   logic [spd_pkg::SQ_BITS-1:0] sq_ff, sq_in;

   logic [CW:0] ab, ba, bd, db;
   logic        wrap;

   // stage 1: |a - b|, both subtractions side by side
   always_comb begin
      ab   = {1'b0, coord_a} - {1'b0, coord_b};
      ba   = {1'b0, coord_b} - {1'b0, coord_a};
      d_in = ab[CW] ? ba[CW-1:0] : ab[CW-1:0];
   end

   // stage 2: wrap when twice the difference exceeds the box
   always_comb begin
      wrap = periodic && ({d_ff, 1'b0} > {1'b0, box});
      bd   = {1'b0, box} - {1'b0, d_ff};
      db   = {1'b0, d_ff} - {1'b0, box};
      if (wrap) begin
         w_in = bd[CW] ? db[CW-1:0] : bd[CW-1:0];
      end else begin
         w_in = d_ff;
      end
   end

   // stage 3: square
   assign sq_in = w_ff * w_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff  <= d_in;
         w_ff  <= w_in;
         sq_ff <= sq_in;
      end
   end

   assign sq = sq_ff;

endmodule

// ===== src/spd_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit per cell.
// Takes two radicand bits, trial-subtracts 4*root+1, hands on to the next cell.
// Depends on spd_pkg.
module spd_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  spd_pkg::root_type work_i,
   input  spd_pkg::side_type side_i,
   output spd_pkg::root_type work_o,
   output spd_pkg::side_type side_o
);

   localparam int RB = spd_pkg::ROOT_BITS;
   localparam int SB = spd_pkg::SQ_BITS;
   localparam int MB = spd_pkg::REM_BITS;

   spd_pkg::root_type work_ff, work_in;
   spd_pkg::side_type side_ff;

   logic [MB-1:0] shifted;
   logic [MB-1:0] trial;

   // restoring step
   always_comb begin
      shifted = {work_i.rem[RB-1:0], work_i.rad[SB-1 -: 2]};
      trial   = {work_i.root, 2'b01};
      work_in.rad = {work_i.rad[SB-3:0], 2'b00};
      if (shifted >= trial) begin
         work_in.rem  = shifted - trial;
         work_in.root = {work_i.root[RB-2:0], 1'b1};
      end else begin
         work_in.rem  = shifted;
         work_in.root = {work_i.root[RB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff <= side_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         work_ff <= work_in;
      end
   end

   assign work_o = work_ff;
   assign side_o = side_ff;

endmodule

// ===== src/spd_out_skid.sv =====
// Output register with a skid stage behind it.
// Ready towards the pipe is registered: it drops only once the skid holds a beat.
// Depends on spd_pkg.
module spd_out_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  spd_pkg::out_type in_beat,
   output logic             in_ready,
   output logic             out_valid,
   output spd_pkg::out_type out_beat,
   input  logic             out_ready
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   spd_pkg::out_type out_ff, out_in;
   spd_pkg::out_type skid_ff, skid_in;
   logic             take;

   always_comb begin
      take          = out_valid_ff && out_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // pipe is held, drain the skid first
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_in       = in_beat;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = in_beat;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_beat  = out_ff;

`ifndef ASSERT_OFF
   // a beat in the skid always has one ahead of it
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while the output register is empty");

   // a beat arriving at a stalled output must land in the skid
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !skid_valid_ff && out_valid_ff && !out_ready) |=> skid_valid_ff)
      else $error("beat arriving at a stalled output was lost");
`endif

endmodule

// ===== src/sphere_pair_distance_periodic_core.sv =====
// Sphere pair centre distance with optional minimum-image wrap, top level.
// Axis lanes, sum and compare stages, a chain of square-root cells and the output skid.
// Depends on spd_pkg, spd_axis_cell, spd_sqrt_cell and spd_out_skid.
//
// Takes one sphere pair per clock while the output skid is empty and returns one
// result per pair, in order. The pipeline holds three axis-lane stages, three
// stages that sum the squares and compare against the squared radius sum, one
// square-root cell per root bit (32 cells, one bit each), then the output register.
// A skid stage behind the output holds one beat so that the pipe keeps moving when
// back-pressure first arrives; req_tready falls only when that skid is occupied.
// Separated pairs report the radius sum with the separated flag set. Configuration
// writes must be made while no pair is in flight.
module sphere_pair_distance_periodic_core (
   input  logic                              clock,
   input  logic                              reset,
   // request beat
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata, low bit up: first_x, first_y, first_z, second_x, second_y, second_z,
   // radius_sum, pair_tag
   input  logic [spd_pkg::REQ_W-1:0]         req_tdata,
   // response beat
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata, low bit up: centre_distance, tag_out
   output logic [spd_pkg::RSP_W-1:0]         rsp_tdata,
   // tuser: separated
   output logic                              rsp_tuser,
   // configuration write port
   input  logic                              csr_we,
   input  logic [spd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [spd_pkg::COORD_BITS-1:0]    csr_wdata
);

   localparam int CW     = spd_pkg::COORD_BITS;
   localparam int SB     = spd_pkg::SQ_BITS;
   localparam int RB     = spd_pkg::ROOT_BITS;
   localparam int CELLS  = spd_pkg::ROOT_BITS;
   localparam int STAGES = 6;

   // configuration registers
   logic          periodic_ff;
   logic [CW-1:0] box_x_ff, box_y_ff, box_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_ff <= 1'b0;
         box_x_ff    <= '0;
         box_y_ff    <= '0;
         box_z_ff    <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            spd_pkg::CSR_PERIODIC_MODE: periodic_ff <= csr_wdata[0];
            spd_pkg::CSR_BOX_SIZE_X:    box_x_ff    <= csr_wdata;
            spd_pkg::CSR_BOX_SIZE_Y:    box_y_ff    <= csr_wdata;
            spd_pkg::CSR_BOX_SIZE_Z:    box_z_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipe advances unless the output skid is occupied
   logic en;
   assign req_tready = en;

   // request fields
   logic [CW-1:0] first_x, first_y, first_z, second_x, second_y, second_z;
   assign first_x  = req_tdata[0*CW +: CW];
   assign first_y  = req_tdata[1*CW +: CW];
   assign first_z  = req_tdata[2*CW +: CW];
   assign second_x = req_tdata[3*CW +: CW];
   assign second_y = req_tdata[4*CW +: CW];
   assign second_z = req_tdata[5*CW +: CW];

   // axis lanes
   logic [SB-1:0] sq_x, sq_y, sq_z;

   spd_axis_cell u_lane_x (
      .clock(clock), .en(en), .periodic(periodic_ff), .box(box_x_ff),
      .coord_a(first_x), .coord_b(second_x), .sq(sq_x)
   );
   spd_axis_cell u_lane_y (
      .clock(clock), .en(en), .periodic(periodic_ff), .box(box_y_ff),
      .coord_a(first_y), .coord_b(second_y), .sq(sq_y)
   );
   spd_axis_cell u_lane_z (
      .clock(clock), .en(en), .periodic(periodic_ff), .box(box_z_ff),
      .coord_a(first_z), .coord_b(second_z), .sq(sq_z)
   );

   // side-band for the front stages
   spd_pkg::side_type side_ff [STAGES];
   spd_pkg::side_type side_in [STAGES];

   // sum and compare datapath
   logic [SB-1:0] rsq3_ff, rsq4_ff, rsq5_ff;
   logic [SB:0]   part4_ff;
   logic [SB-1:0] sqz4_ff;
   logic [SB+1:0] sq5_ff;
   logic [SB-1:0] rad6_ff;

   always_comb begin
      side_in[0].valid = req_tvalid;
      side_in[0].sep   = 1'b0;
      side_in[0].rsum  = req_tdata[6*CW +: CW];
      side_in[0].tag   = req_tdata[7*CW +: spd_pkg::TAG_BITS];
      for (int i = 1; i < STAGES; i++) begin
         side_in[i] = side_ff[i-1];
      end
      // last front stage decides separation
      side_in[STAGES-1].sep = sq5_ff > {2'b00, rsq5_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsq3_ff  <= side_ff[1].rsum * side_ff[1].rsum;
         part4_ff <= {1'b0, sq_x} + {1'b0, sq_y};
         sqz4_ff  <= sq_z;
         rsq4_ff  <= rsq3_ff;
         sq5_ff   <= {1'b0, part4_ff} + {2'b00, sqz4_ff};
         rsq5_ff  <= rsq4_ff;
         // separated pairs never use the root, so the top bits may go
         rad6_ff  <= sq5_ff[SB-1:0];
      end
   end

   // square-root chain
   spd_pkg::root_type work_chain [CELLS+1];
   spd_pkg::side_type side_chain [CELLS+1];

   always_comb begin
      work_chain[0].rem  = '0;
      work_chain[0].root = '0;
      work_chain[0].rad  = rad6_ff;
      side_chain[0]      = side_ff[STAGES-1];
   end

   for (genvar k = 0; k < CELLS; k++) begin : g_root
      spd_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .en(en),
         .work_i(work_chain[k]), .side_i(side_chain[k]),
         .work_o(work_chain[k+1]), .side_o(side_chain[k+1])
      );
   end

   // result beat
   spd_pkg::out_type res_beat, rsp_beat;
   logic             res_valid;

   always_comb begin
      res_valid       = side_chain[CELLS].valid && en;
      res_beat.sep    = side_chain[CELLS].sep;
      res_beat.tag    = side_chain[CELLS].tag;
      res_beat.centre = side_chain[CELLS].sep ? side_chain[CELLS].rsum
                                              : work_chain[CELLS].root[RB-1:0];
   end

   spd_out_skid u_out (
      .clock(clock), .reset(reset),
      .in_valid(res_valid), .in_beat(res_beat), .in_ready(en),
      .out_valid(rsp_tvalid), .out_beat(rsp_beat), .out_ready(rsp_tready)
   );

   assign rsp_tdata = {rsp_beat.tag, rsp_beat.centre};
   assign rsp_tuser = rsp_beat.sep;

`ifndef ASSERT_OFF
   // root chain remainder stays within 2*root for a live pair
   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      side_chain[CELLS].valid |->
         (work_chain[CELLS].rem <= {1'b0, work_chain[CELLS].root, 1'b0}))
      else $error("square-root remainder out of range");

   // a held pipe keeps its last stage
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(side_chain[CELLS]))
      else $error("pipe moved while stalled");

   // a stalled pipe only happens behind an offered result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !en |-> rsp_tvalid)
      else $error("pipe stalled with no result offered");
`endif

endmodule

// ===== tb/spd_distance_checker.sv =====
// Result checker for the sphere pair distance core: predicts the distance of every pair beat.
// Watches the request, response and CSR ports and compares each response field by field.
// Depends on spd_pkg.
`timescale 1ns / 100ps

module spd_distance_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // tdata, low bit up: first_x, first_y, first_z, second_x, second_y, second_z,
   // radius_sum, pair_tag
   input  logic [spd_pkg::REQ_W-1:0]      req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata, low bit up: centre_distance, tag_out
   input  logic [spd_pkg::RSP_W-1:0]      rsp_tdata,
   // tuser: separated
   input  logic                           rsp_tuser,
   input  logic                           csr_we,
   input  logic [spd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [spd_pkg::COORD_BITS-1:0] csr_wdata,
   output int                             mismatches,
   output int                             in_flight
);

   typedef struct packed {
      logic [spd_pkg::COORD_BITS-1:0] centre;
      logic                           sep;
      logic [spd_pkg::TAG_BITS-1:0]   tag;
   } pair_result_type;

   pair_result_type awaited_distances[$];

   // shadow of the geometry registers
   logic                           wrap_on;
   logic [spd_pkg::COORD_BITS-1:0] box_len [3];

   initial begin
      mismatches = 0;
      in_flight  = 0;
   end

   task automatic report_fault(input string what);
      $display("%0t ns checker: %s", $time, what);
      mismatches++;
   endtask

   // minimum-image difference on one axis; 2*d > box is exact, no halving of the box
   function automatic logic [spd_pkg::COORD_BITS-1:0] axis_gap(
      input logic [spd_pkg::COORD_BITS-1:0] a,
      input logic [spd_pkg::COORD_BITS-1:0] b,
      input logic [spd_pkg::COORD_BITS-1:0] box);
      logic [spd_pkg::COORD_BITS-1:0] d;
      logic [spd_pkg::COORD_BITS:0]   twice;
      d     = (a >= b) ? a - b : b - a;
      twice = {d, 1'b0};
      if (wrap_on && twice > {1'b0, box})
         d = (box >= d) ? box - d : d - box;
      return d;
   endfunction

   // truncated square root, one bit at a time from the top
   function automatic logic [spd_pkg::COORD_BITS-1:0] floor_root(
      input logic [spd_pkg::SQ_BITS+1:0] v);
      logic [spd_pkg::COORD_BITS-1:0] root;
      logic [spd_pkg::COORD_BITS-1:0] cand;
      logic [spd_pkg::SQ_BITS+1:0]    cand_w;
      int                             k;
      root = '0;
      for (k = spd_pkg::COORD_BITS - 1; k >= 0; k--) begin
         cand   = root | (spd_pkg::COORD_BITS'(1) << k);
         cand_w = cand;
         if (cand_w * cand_w <= v)
            root = cand;
      end
      return root;
   endfunction

   function automatic pair_result_type predict_distance(
      input logic [spd_pkg::REQ_W-1:0] beat);
      logic [spd_pkg::COORD_BITS-1:0] f [spd_pkg::REQ_FIELDS];
      logic [spd_pkg::SQ_BITS+1:0]    wx, wy, wz, wr, sq, rsq;
      pair_result_type                res;
      int                             k;
      for (k = 0; k < spd_pkg::REQ_FIELDS; k++)
         f[k] = beat[k*spd_pkg::COORD_BITS +: spd_pkg::COORD_BITS];
      wx  = axis_gap(f[0], f[3], box_len[0]);
      wy  = axis_gap(f[1], f[4], box_len[1]);
      wz  = axis_gap(f[2], f[5], box_len[2]);
      wr  = f[6];
      sq  = wx * wx + wy * wy + wz * wz;
      rsq = wr * wr;
      // equal squares count as touching, not separated
      if (sq > rsq) begin
         res.centre = f[6];
         res.sep    = 1'b1;
      end else begin
         res.centre = floor_root(sq);
         res.sep    = 1'b0;
      end
      res.tag = f[7];
      return res;
   endfunction

   always @(posedge clock) begin
      pair_result_type                want;
      logic [spd_pkg::COORD_BITS-1:0] got_centre;
      logic [spd_pkg::TAG_BITS-1:0]   got_tag;
      if (reset) begin
         wrap_on = 1'b0;
         foreach (box_len[a]) box_len[a] = '0;
      end else begin
         // response beat: compare against the oldest outstanding pair
         if (rsp_tvalid && rsp_tready) begin
            got_centre = rsp_tdata[spd_pkg::COORD_BITS-1:0];
            got_tag    = rsp_tdata[spd_pkg::COORD_BITS +: spd_pkg::TAG_BITS];
            if (awaited_distances.size() == 0) begin
               report_fault($sformatf("response beat with no pair outstanding, tag %h",
                                      got_tag));
            end else begin
               want = awaited_distances.pop_front();
               if (got_centre !== want.centre)
                  report_fault($sformatf("tag %h: centre_distance %h, predicted %h",
                                         want.tag, got_centre, want.centre));
               if (rsp_tuser !== want.sep)
                  report_fault($sformatf("tag %h: separated %b, predicted %b",
                                         want.tag, rsp_tuser, want.sep));
               if (got_tag !== want.tag)
                  report_fault($sformatf("tag_out %h, predicted %h", got_tag, want.tag));
            end
         end
         // request beat
         if (req_tvalid && req_tready)
            awaited_distances.push_back(predict_distance(req_tdata));
         // register write
         if (csr_we) begin
            case (csr_addr)
               spd_pkg::CSR_PERIODIC_MODE: wrap_on    = csr_wdata[0];
               spd_pkg::CSR_BOX_SIZE_X:    box_len[0] = csr_wdata;
               spd_pkg::CSR_BOX_SIZE_Y:    box_len[1] = csr_wdata;
               spd_pkg::CSR_BOX_SIZE_Z:    box_len[2] = csr_wdata;
               default: ;
            endcase
         end
      end
      in_flight = awaited_distances.size();
   end

endmodule

// ===== tb/tb_sphere_pair_distance_periodic_core.sv =====
// Top of the sphere pair distance testbench: clock, reset, pair stimulus and geometry writes.
// Directed pairs first, then random pairs under several box settings; verdict from the checker.
// Depends on spd_pkg, sphere_pair_distance_periodic_core and spd_distance_checker.
`timescale 1ns / 100ps

module tb_sphere_pair_distance_periodic_core;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [spd_pkg::REQ_W-1:0]      req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [spd_pkg::RSP_W-1:0]      rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_we;
   logic [spd_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [spd_pkg::COORD_BITS-1:0] csr_wdata;

   int                             mismatches;
   int                             in_flight;
   // no idle bursts on either side while set
   logic                           calm;
   logic [spd_pkg::COORD_BITS-1:0] cur_box [3];

   sphere_pair_distance_periodic_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   spd_distance_checker distance_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .in_flight  (in_flight)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop
   initial begin
      #2_000_000;
      $display("sphere_pair_distance_periodic_core: mismatch");
      $finish;
   end

   // response side: random stall bursts on rsp_tready
   initial begin
      int stall;
      stall      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
               stall = $urandom_range(1, 3);
         end
      end
   end

   function automatic logic [spd_pkg::REQ_W-1:0] pack_pair(
      input logic [31:0] fx, input logic [31:0] fy, input logic [31:0] fz,
      input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz,
      input logic [31:0] rsum, input logic [31:0] tag);
      return {tag, rsum, sz, sy, sx, fz, fy, fx};
   endfunction

   // one pair beat; holds tvalid until accepted, with an optional gap before it
   task automatic send_pair(input logic [spd_pkg::REQ_W-1:0] beat);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait until every pair has come back
   task automatic pause_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [spd_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
   endtask

   task automatic load_geometry(input logic mode, input logic [31:0] bx,
                                input logic [31:0] by, input logic [31:0] bz);
      pause_requests();
      write_csr(spd_pkg::CSR_PERIODIC_MODE, {31'b0, mode});
      write_csr(spd_pkg::CSR_BOX_SIZE_X, bx);
      write_csr(spd_pkg::CSR_BOX_SIZE_Y, by);
      write_csr(spd_pkg::CSR_BOX_SIZE_Z, bz);
      @(negedge clock);
      csr_we     <= 1'b0;
      cur_box[0] = bx;
      cur_box[1] = by;
      cur_box[2] = bz;
   endtask

   // random pair: wide random, near neighbours, large offsets under a large radius sum, or inside the box
   function automatic logic [spd_pkg::REQ_W-1:0] random_pair();
      logic [31:0] p [3];
      logic [31:0] q [3];
      logic [31:0] off;
      logic [31:0] rsum;
      int          kind;
      kind = $urandom_range(0, 3);
      rsum = $urandom;
      for (int a = 0; a < 3; a++) begin
         p[a] = $urandom;
         case (kind)
            0: q[a] = $urandom;
            1, 2: begin
               off  = (kind == 1) ? $urandom_range(0, 32'h0010_0000)
                                  : $urandom_range(0, 32'h3FFF_FFFF);
               q[a] = $urandom_range(0, 1) ? p[a] + off : p[a] - off;
            end
            default: begin
               p[a] = $urandom_range(0, cur_box[a]);
               q[a] = $urandom_range(0, cur_box[a]);
            end
         endcase
      end
      case (kind)
         1:       rsum = $urandom >> $urandom_range(8, 20);
         2:       rsum = $urandom | 32'h8000_0000;
         3:       rsum = $urandom >> $urandom_range(0, 31);
         default: ;
      endcase
      return pack_pair(p[0], p[1], p[2], q[0], q[1], q[2], rsum, $urandom);
   endfunction

   initial begin
      logic        mode;
      logic [31:0] bx, by, bz;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = spd_pkg::CSR_PERIODIC_MODE;
      csr_wdata  = '0;
      calm       = 1'b0;
      foreach (cur_box[a]) cur_box[a] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // plain mode straight from reset
      send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pack_pair('1, '1, '1, 0, 0, 0, '1, '1));
      send_pair(pack_pair(0, 0, 0, '1, '1, '1, 0, 32'h0000_0001));
      // 3-4-5 triangle exactly on the radius sum, then just inside and just outside
      send_pair(pack_pair(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 32'h0005_0000, 2));
      send_pair(pack_pair(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 32'h0005_0001, 3));
      send_pair(pack_pair(32'h0003_0001, 32'h0004_0000, 0, 0, 0, 0, 32'h0005_0000, 4));
      // radius sum below one: 0.25 apart touching, 0.75 apart separated
      send_pair(pack_pair(32'h0000_4000, 0, 0, 0, 0, 0, 32'h0000_8000, 5));
      send_pair(pack_pair(0, 0, 0, 32'h0000_C000, 0, 0, 32'h0000_8000, 6));
      // full-scale single axis equal to the radius sum
      send_pair(pack_pair('1, 0, 0, 0, 0, 0, '1, 7));
      // root of 2 LSB squared truncates to 1
      send_pair(pack_pair(1, 1, 0, 0, 0, 0, 32'h0001_0000, 32'h8000_0000));

      // periodic: x box 10.0, y box zero, z box full scale
      load_geometry(1'b1, 32'h000A_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      // exactly half the box stays, one LSB more wraps
      send_pair(pack_pair(32'h0002_0000, 0, 0, 32'h0007_0000, 0, 0, '1, 11));
      send_pair(pack_pair(32'h0002_0000, 0, 0, 32'h0007_0001, 0, 0, '1, 12));
      // difference of 25.0 beyond a 10.0 box
      send_pair(pack_pair(0, 0, 0, 32'h0019_0000, 0, 0, '1, 13));
      // zero box wraps any difference to itself, then differences against the full-scale z box
      send_pair(pack_pair(0, 7, 0, 0, 0, 0, '1, 14));
      send_pair(pack_pair(0, 0, '1, 0, 0, 0, '1, 15));
      send_pair(pack_pair(0, 0, 32'h8000_0000, 0, 0, 0, '1, 16));
      send_pair(pack_pair(32'h0001_0000, 3, 32'h1234_5678,
                          32'h0009_0000, 32'h0010_0000, 32'hFEDC_BA98, 32'h0000_8000, 17));

      // random pairs under several geometries
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin mode = 1'b0; bx = $urandom; by = $urandom; bz = $urandom; end
            1: begin mode = 1'b1; bx = $urandom; by = $urandom; bz = $urandom; end
            2: begin
               mode = 1'b1;
               bx   = $urandom_range(0, 32'h0040_0000);
               by   = $urandom_range(0, 32'h0040_0000);
               bz   = $urandom_range(0, 32'h0040_0000);
            end
            3: begin mode = 1'b1; bx = '0; by = '0; bz = '0; end
            4: begin mode = 1'b1; bx = '1; by = '1; bz = '1; end
            default: begin mode = 1'b1; bx = $urandom; by = $urandom >> 8; bz = '1; end
         endcase
         load_geometry(mode, bx, by, bz);
         for (int n = 0; n < 90; n++) begin
            if (n % 30 == 0)
               calm = ($urandom_range(0, 3) == 0);
            if (phase == 5 && n >= 30)
               calm = 1'b1;
            // let the pipe empty once in the middle of a phase
            if (phase == 2 && n == 45)
               pause_requests();
            send_pair(random_pair());
         end
      end

      pause_requests();
      repeat (60) @(negedge clock);
      if (mismatches == 0 && in_flight == 0)
         $display("sphere_pair_distance_periodic_core: match");
      else
         $display("sphere_pair_distance_periodic_core: mismatch");
      $finish;
   end

endmodule
